// File: src/sfd_pkg.sv
package sfd_pkg;

   localparam logic [7:0] SYNC_RESET = 8'hAA;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [1:0] STATUS_GOOD    = 2'd0;
   localparam logic [1:0] STATUS_BAD_SUM = 2'd1;
   localparam logic [1:0] STATUS_SHORT   = 2'd2;

   // received word with its sync match flag, as queued between front and back
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       is_sync;
   } rx_item_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] frame_command;
      logic [7:0] payload_byte;
      logic [1:0] status;
   } rsp_item_type;

endpackage

// File: src/sfd_fifo.sv
module sfd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fifo count beyond depth");
   a_push_full: assert property (@(posedge clock) disable iff (reset)
      (full && push && !do_pop) |=> $stable(count_ff))
      else $error("fifo count moved on a refused push");
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (empty && !push) |=> empty)
      else $error("fifo filled without a push");
`endif
endmodule

// File: src/sfd_front.sv
module sfd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [7:0]           csr_sync_value,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [7:0]           req_rx_byte,
   output logic                 q_push,
   output sfd_pkg::rx_item_type q_data,
   input  logic                 q_full
);
   import sfd_pkg::*;

   logic [7:0] sync_ff, sync_in;

   assign csr_ready = 1'b1;
   assign sync_in   = (csr_valid && csr_ready) ? csr_sync_value : sync_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= SYNC_RESET;
      end else begin
         sync_ff <= sync_in;
      end
   end

   // sync match is tagged here so the back end only looks at a flag
   assign req_full        = q_full;
   assign q_push          = req_push && !q_full;
   assign q_data.rx_byte  = req_rx_byte;
   assign q_data.is_sync  = (req_rx_byte == sync_ff);
endmodule

// File: src/sfd_back.sv
module sfd_back #(
   parameter int LENGTH_FIELD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  sfd_pkg::rx_item_type  in_data,
   output logic                  in_pop,
   output logic                  out_push,
   output sfd_pkg::rsp_item_type out_data,
   input  logic                  out_full
);
   import sfd_pkg::*;

   localparam int LEN_RAW   = (LENGTH_FIELD_BITS + 7) / 8;
   localparam int LEN_BYTES = (LEN_RAW < 2) ? 2 : ((LEN_RAW > 4) ? 4 : LEN_RAW);
   localparam int LEN_W     = (LENGTH_FIELD_BITS < 16) ? 16 :
                              ((LENGTH_FIELD_BITS > 32) ? 32 : LENGTH_FIELD_BITS);
   localparam int ACC_W     = LEN_BYTES * 8;
   localparam int IDX_W     = $clog2(LEN_BYTES);

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_CMD,
      PH_LEN,
      PH_PAYLOAD,
      PH_CK_LO,
      PH_CK_HI
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [ACC_W-1:0] len_acc_ff, len_acc_in;
   logic [LEN_W-1:0] remain_ff, remain_in;
   logic [15:0]      sum_ff, sum_in;
   logic [7:0]       ck_lo_ff, ck_lo_in;

   logic             take;
   logic [7:0]       b;
   logic [15:0]      sum_add;
   logic [ACC_W-1:0] len_next;
   logic [LEN_W-1:0] len_val;

   assign take    = in_valid && !out_full;
   assign in_pop  = take;
   assign b       = in_data.rx_byte;
   assign sum_add = sum_ff + {8'd0, b};

   always_comb begin
      len_next = len_acc_ff;
      for (int i = 0; i < LEN_BYTES; i++) begin
         if (idx_ff == IDX_W'(i)) begin
            len_next[i*8 +: 8] = b;
         end
      end
   end

   assign len_val = len_next[LEN_W-1:0];

   always_comb begin
      phase_in   = phase_ff;
      idx_in     = idx_ff;
      cmd_in     = cmd_ff;
      len_acc_in = len_acc_ff;
      remain_in  = remain_ff;
      sum_in     = sum_ff;
      ck_lo_in   = ck_lo_ff;
      out_push   = 1'b0;
      out_data.kind          = KIND_DATA;
      out_data.frame_command = cmd_ff;
      out_data.payload_byte  = 8'd0;
      out_data.status        = STATUS_GOOD;
      if (take) begin
         case (phase_ff)
            PH_HUNT: begin
               if (in_data.is_sync) begin
                  sum_in     = {8'd0, b};
                  len_acc_in = '0;
                  phase_in   = PH_CMD;
               end
            end
            PH_CMD: begin
               cmd_in   = b;
               sum_in   = sum_add;
               idx_in   = '0;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               sum_in     = sum_add;
               len_acc_in = len_next;
               idx_in     = idx_ff + 1'b1;
               if (idx_ff == IDX_W'(LEN_BYTES - 1)) begin
                  idx_in = '0;
                  if (len_val < LEN_W'(2)) begin
                     out_push        = 1'b1;
                     out_data.kind   = KIND_END;
                     out_data.status = STATUS_SHORT;
                     phase_in        = PH_HUNT;
                  end else if (len_val == LEN_W'(2)) begin
                     phase_in = PH_CK_LO;
                  end else begin
                     remain_in = len_val - LEN_W'(2);
                     phase_in  = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               sum_in                = sum_add;
               remain_in             = remain_ff - 1'b1;
               out_push              = 1'b1;
               out_data.payload_byte = b;
               if (remain_ff == LEN_W'(1)) begin
                  phase_in = PH_CK_LO;
               end
            end
            PH_CK_LO: begin
               ck_lo_in = b;
               phase_in = PH_CK_HI;
            end
            PH_CK_HI: begin
               out_push        = 1'b1;
               out_data.kind   = KIND_END;
               out_data.status = ({b, ck_lo_ff} == ~sum_ff) ? STATUS_GOOD : STATUS_BAD_SUM;
               phase_in        = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         idx_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
      end
      cmd_ff     <= cmd_in;
      len_acc_ff <= len_acc_in;
      remain_ff  <= remain_in;
      sum_ff     <= sum_in;
      ck_lo_ff   <= ck_lo_in;
   end

`ifndef SYNTH
   a_reset_hunt: assert property (@(posedge clock)
      reset |=> (phase_ff == PH_HUNT))
      else $error("not hunting after reset");
   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (remain_ff != '0))
      else $error("payload phase with nothing left");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      out_push |-> (!out_full && in_valid))
      else $error("result pushed without room or word");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LEN) |-> (idx_ff <= IDX_W'(LEN_BYTES - 1)))
      else $error("length byte index out of range");
`endif
endmodule

// File: src/serial_frame_deframer.sv
// channel   direction  handshake            payload
// req_      in         req_push / req_full  req_rx_byte
// rsp_      out        rsp_pop / rsp_empty  rsp_kind, rsp_frame_command,
//                                           rsp_payload_byte, rsp_status
// csr_      in         csr_valid/csr_ready  csr_sync_value
//
// one word per cycle sustained while the result queue has room; a word is
// written into the input queue, then the frame state machine pops it and
// pushes its result, if it has one, into the result queue
// the frame state machine takes a word whenever the result queue has room; req_full rises only
// when the two-entry input queue backs up behind a full result queue
// synchronous reset: hunting, both queues empty, sync value 0xaa
module serial_frame_deframer #(
   parameter int LENGTH_FIELD_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_kind,
   output logic [7:0] rsp_frame_command,
   output logic [7:0] rsp_payload_byte,
   output logic [1:0] rsp_status,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_sync_value
);
   import sfd_pkg::*;

   localparam int RX_W  = $bits(rx_item_type);
   localparam int RSP_W = $bits(rsp_item_type);

   rx_item_type  front_data, back_in;
   rsp_item_type back_out, rsp_item;
   logic         front_push, mid_full, mid_empty, back_pop;
   logic         back_push, out_full;
   logic [RX_W-1:0]  mid_pop_data;
   logic [RSP_W-1:0] out_pop_data;

   sfd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_sync_value (csr_sync_value),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_rx_byte    (req_rx_byte),
      .q_push         (front_push),
      .q_data         (front_data),
      .q_full         (mid_full)
   );

   sfd_fifo #(.WIDTH(RX_W), .DEPTH(2)) u_mid_q (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_data),
      .full      (mid_full),
      .pop       (back_pop),
      .pop_data  (mid_pop_data),
      .empty     (mid_empty)
   );

   assign back_in = mid_pop_data;

   sfd_back #(.LENGTH_FIELD_BITS(LENGTH_FIELD_BITS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (!mid_empty),
      .in_data  (back_in),
      .in_pop   (back_pop),
      .out_push (back_push),
      .out_data (back_out),
      .out_full (out_full)
   );

   sfd_fifo #(.WIDTH(RSP_W), .DEPTH(2)) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_out),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_pop_data),
      .empty     (rsp_empty)
   );

   assign rsp_item          = out_pop_data;
   assign rsp_kind          = rsp_item.kind;
   assign rsp_frame_command = rsp_item.frame_command;
   assign rsp_payload_byte  = rsp_item.payload_byte;
   assign rsp_status        = rsp_item.status;
endmodule

// File: tb/serial_frame_deframer_tb.sv
module serial_frame_deframer_tb;
   import sfd_pkg::*;

   typedef enum logic [2:0] {
      FR_HUNT,
      FR_COMMAND,
      FR_LENGTH,
      FR_PAYLOAD,
      FR_SUM_LO,
      FR_SUM_HI
   } frame_phase_type;

   logic       clock;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic [7:0] req_rx_byte;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic       rsp_kind;
   logic [7:0] rsp_frame_command;
   logic [7:0] rsp_payload_byte;
   logic [1:0] rsp_status;
   logic       csr_valid;
   logic       csr_ready;
   logic [7:0] csr_sync_value;

   // deframer state as the testbench tracks it
   frame_phase_type rx_phase;
   logic [7:0]   sync_cfg;
   logic [31:0]  rx_position;
   logic [7:0]   rx_command;
   logic [31:0]  rx_length;
   logic [15:0]  rx_sum;
   logic [7:0]   rx_sum_lo;

   rsp_item_type expected_results [$];
   logic [7:0]   frame_payload [$];

   int send_idle_pct;
   int recv_idle_pct;
   int error_count;
   int words_sent;
   int frames_sent;
   int results_checked;
   int sync_writes;

   serial_frame_deframer dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_rx_byte       (req_rx_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_kind          (rsp_kind),
      .rsp_frame_command (rsp_frame_command),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_sync_value    (csr_sync_value)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic void reset_deframer_state();
      sync_cfg = SYNC_RESET;
      rx_phase = FR_HUNT;
      rx_position = '0;
      rx_command = '0;
      rx_length = '0;
      rx_sum = '0;
      rx_sum_lo = '0;
      expected_results.delete();
   endfunction

   function automatic void push_result(logic kind, logic [7:0] data, logic [1:0] status);
      rsp_item_type item;
      item.kind = kind;
      item.frame_command = rx_command;
      item.payload_byte = data;
      item.status = status;
      expected_results.push_back(item);
   endfunction

   // advance the tracked state by one accepted word
   function automatic void deframe_word(logic [7:0] b);
      logic [15:0] got;
      case (rx_phase)
         FR_HUNT: begin
            if (b == sync_cfg) begin
               rx_sum = {8'h00, b};
               rx_command = '0;
               rx_length = '0;
               rx_position = '0;
               rx_sum_lo = '0;
               rx_phase = FR_COMMAND;
            end
         end
         FR_COMMAND: begin
            rx_command = b;
            rx_sum = rx_sum + b;
            rx_position = '0;
            rx_phase = FR_LENGTH;
         end
         FR_LENGTH: begin
            rx_sum = rx_sum + b;
            rx_length = rx_length | (32'(b) << (8 * rx_position[1:0]));
            rx_position = rx_position + 1;
            if (rx_position == 4) begin
               rx_position = '0;
               if (rx_length < 2) begin
                  rx_phase = FR_HUNT;
                  push_result(KIND_END, 8'h00, STATUS_SHORT);
               end else if (rx_length == 2) begin
                  rx_phase = FR_SUM_LO;
               end else begin
                  rx_phase = FR_PAYLOAD;
               end
            end
         end
         FR_PAYLOAD: begin
            rx_sum = rx_sum + b;
            rx_position = rx_position + 1;
            if (rx_position >= rx_length - 2)
               rx_phase = FR_SUM_LO;
            push_result(KIND_DATA, b, STATUS_GOOD);
         end
         FR_SUM_LO: begin
            rx_sum_lo = b;
            rx_phase = FR_SUM_HI;
         end
         FR_SUM_HI: begin
            got = {b, rx_sum_lo};
            rx_phase = FR_HUNT;
            push_result(KIND_END, 8'h00, (got == ~rx_sum) ? STATUS_GOOD : STATUS_BAD_SUM);
         end
         default: rx_phase = FR_HUNT;
      endcase
   endfunction

   always @(negedge clock)
      rsp_pop <= ($urandom_range(99) >= recv_idle_pct);

   function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin : result_check
      rsp_item_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         results_checked++;
         if (expected_results.size() == 0) begin
            error_count++;
            $display({"%0t: result with nothing expected, expected none, ",
                      "got kind %0h cmd %0h data %0h status %0h"},
                     $time, rsp_kind, rsp_frame_command, rsp_payload_byte, rsp_status);
         end else begin
            want = expected_results.pop_front();
            compare_field("kind", 8'(want.kind), 8'(rsp_kind));
            compare_field("frame_command", want.frame_command, rsp_frame_command);
            compare_field("payload_byte", want.payload_byte, rsp_payload_byte);
            compare_field("status", 8'(want.status), 8'(rsp_status));
         end
      end
   end

   task automatic send_word(input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_full);
      words_sent++;
      deframe_word(b);
   endtask

   // hold off the sender until every result is out and the pipe has settled
   task automatic wait_drained();
      @(negedge clock);
      req_push <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_sync_value(input logic [7:0] value);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_sync_value <= value;
      do @(posedge clock); while (!csr_ready);
      sync_cfg = value;
      sync_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // sync, command, length, and if length >= 2 frame_payload and the inverted sum xor sum_flip
   task automatic send_frame(input logic [7:0] sync_b, input logic [7:0] cmd_b,
                             input logic [31:0] len_field, input logic [15:0] sum_flip);
      logic [15:0] sum;
      logic [7:0]  lb;
      sum = {8'h00, sync_b} + cmd_b;
      frames_sent++;
      send_word(sync_b);
      send_word(cmd_b);
      for (int i = 0; i < 4; i++) begin
         lb = len_field[8*i +: 8];
         sum = sum + lb;
         send_word(lb);
      end
      if (len_field < 2)
         return;
      foreach (frame_payload[j]) begin
         sum = sum + frame_payload[j];
         send_word(frame_payload[j]);
      end
      sum = ~sum ^ sum_flip;
      send_word(sum[7:0]);
      send_word(sum[15:8]);
   endtask

   task automatic fill_payload(input int count);
      frame_payload.delete();
      repeat (count) frame_payload.push_back(8'($urandom_range(255)));
   endtask

   function automatic logic [7:0] noise_word();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == sync_cfg);
      return b;
   endfunction

   task automatic test_hunt_noise();
      send_word(8'h00);
      send_word(8'hFF);
   endtask

   task automatic test_short_length();
      frame_payload.delete();
      send_frame(SYNC_RESET, 8'hFF, 32'd0, 16'h0000);
   endtask

   task automatic test_empty_payload_bad_sum();
      frame_payload.delete();
      send_frame(SYNC_RESET, 8'h00, 32'd2, 16'h8000);
   endtask

   task automatic test_sync_in_payload();
      frame_payload = '{SYNC_RESET};
      send_frame(SYNC_RESET, 8'h81, 32'd3, 16'h0000);
   endtask

   // new sync value lands mid-frame: the frame finishes on the old sum,
   // the next hunt uses the new value
   task automatic test_sync_change_mid_frame();
      logic [7:0]  head [6];
      logic [15:0] sum;
      head = '{SYNC_RESET, 8'h7E, 8'h03, 8'h00, 8'h00, 8'h00};
      sum = '0;
      foreach (head[i]) begin
         sum = sum + head[i];
         send_word(head[i]);
      end
      write_sync_value(8'h00);
      send_word(8'h00);
      sum = ~sum;
      send_word(sum[7:0]);
      send_word(sum[15:8]);
      send_word(SYNC_RESET);
      frame_payload.delete();
      send_frame(8'h00, 8'hC3, 32'd1, 16'h0000);
      write_sync_value(8'hFF);
   endtask

   task automatic run_random(input int count, input int s_pct, input int r_pct);
      int start;
      int pick;
      int n;
      logic [15:0] flip;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      write_sync_value(8'($urandom_range(255)));
      start = words_sent;
      while (words_sent - start < count) begin
         pick = $urandom_range(99);
         if (pick < 3) begin
            write_sync_value(8'($urandom_range(255)));
         end else if (pick < 12) begin
            repeat ($urandom_range(1, 3)) send_word(noise_word());
         end else if (pick < 20) begin
            frame_payload.delete();
            send_frame(sync_cfg, 8'($urandom_range(255)), 32'($urandom_range(1)), 16'h0000);
         end else begin
            n = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            fill_payload(n);
            flip = ($urandom_range(99) < 15) ? 16'($urandom_range(1, 16'hFFFF)) : 16'h0000;
            send_frame(sync_cfg, 8'($urandom_range(255)), 32'(n + 2), flip);
         end
      end
   endtask

   // one frame whose length needs the third length word; the run ends
   // partway through its payload
   task automatic test_long_length();
      logic [31:0] len_field;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      len_field = 32'h0001_0002;
      frames_sent++;
      send_word(sync_cfg);
      send_word(8'h5A);
      for (int i = 0; i < 4; i++)
         send_word(len_field[8*i +: 8]);
      repeat (12) send_word(8'($urandom_range(255)));
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_rx_byte = '0;
      csr_valid = 1'b0;
      csr_sync_value = '0;
      send_idle_pct = 38;
      recv_idle_pct = 85;
      error_count = 0;
      words_sent = 0;
      frames_sent = 0;
      results_checked = 0;
      sync_writes = 0;
      reset_deframer_state();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_hunt_noise();
      test_short_length();
      test_empty_payload_bad_sum();
      test_sync_in_payload();
      test_sync_change_mid_frame();
      run_random(150, 38, 85);
      run_random(150, 85, 38);
      run_random(150, 0, 0);
      test_long_length();

      wait_drained();
      repeat (8) @(posedge clock);
      $display("sent %0d words in %0d frames with %0d sync value writes, checked %0d results",
               words_sent, frames_sent, sync_writes, results_checked);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
